// ===== hdl/sjf_nonpreemptive_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shortest-job-first scheduler.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_MACROS_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SJF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define SJF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SJF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// sjf_pkg
// Constants, operation and status codes, and item layouts for the scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

   // Sizes of the ready store and of the job fields.
   localparam int READY_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int BURST_BITS  = 16;
   localparam int TIME_BITS   = 32;
   localparam int IDX_BITS    = $clog2(READY_DEPTH);
   localparam int CNT_BITS    = $clog2(READY_DEPTH + 1);

   // Operation codes carried in the request tuser.
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Status codes of a result item.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   // Request data, last field in the lowest bits.
   typedef struct packed {
      logic [BURST_BITS-1:0] burst_time;
      logic [ID_BITS-1:0]    process_id;
   } req_data_type;

   localparam int RSP_FIELD_BITS = 2 * ID_BITS + BURST_BITS + TIME_BITS + 1 + CNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   // Result data, last field in the lowest bits, zero padded to whole bytes.
   typedef struct packed {
      logic [RSP_PAD_BITS-1:0] pad;
      logic [CNT_BITS-1:0]     ready_count;
      logic [ID_BITS-1:0]      running_id;
      logic                    busy_res;
      logic [TIME_BITS-1:0]    finish_time;
      logic [BURST_BITS-1:0]   finished_burst;
      logic [ID_BITS-1:0]      finished_id;
   } rsp_data_type;

   // Result flags: status in the lowest bits, then the completion flag.
   typedef struct packed {
      logic       finished;
      logic [1:0] status;
   } rsp_user_type;

endpackage

// ===== hdl/sjf_nonpreemptive_scheduler.sv =====
// An arrival item has its result registered in the cycle after it is accepted.
// A tick with nothing running and jobs waiting scans all READY_DEPTH slots through
// one shared burst/age comparator, one slot per cycle, then passes the start and tick states.
// Any other tick passes through the tick state before its result is registered.
// One item at a time: the next item is accepted the cycle after the result is taken.
// Reset is synchronous and active high; it empties the ready store and stops the running job.
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler with a ready store, a sequential
// minimum search over the store, and a tick-driven running job.
// ----------------------------------------------------------------------------
`include "sjf_nonpreemptive_scheduler_macros.svh"

module sjf_nonpreemptive_scheduler
   import sjf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ID_BITS+BURST_BITS-1:0] req_tdata,  // process_id, burst_time
   input  logic [0:0]               req_tuser,       // operation

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // finished_id, finished_burst, finish_time, busy_res, running_id, ready_count
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [2:0]               rsp_tuser        // status, finished
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_TICK  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(READY_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(READY_DEPTH);

   // Ready store.
   logic [READY_DEPTH-1:0]  slot_valid_ff;
   logic [ID_BITS-1:0]      slot_id_ff    [READY_DEPTH];
   logic [BURST_BITS-1:0]   slot_burst_ff [READY_DEPTH];
   logic [TIME_BITS-1:0]    slot_order_ff [READY_DEPTH];

   // Control and job state.
   logic [2:0]              state_ff, state_in;
   logic [TIME_BITS-1:0]    arrival_cnt_ff, arrival_cnt_in;
   logic [CNT_BITS-1:0]     ready_cnt_ff, ready_cnt_in;
   logic                    run_active_ff, run_active_in;
   logic [ID_BITS-1:0]      run_id_ff, run_id_in;
   logic [BURST_BITS-1:0]   run_burst_ff, run_burst_in;
   logic [BURST_BITS-1:0]   run_rem_ff, run_rem_in;
   logic [TIME_BITS-1:0]    tick_cnt_ff, tick_cnt_in;

   // Scan state.
   logic [IDX_BITS-1:0]     scan_idx_ff, scan_idx_in;
   logic                    found_ff, found_in;
   logic [IDX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic [ID_BITS-1:0]      best_id_ff, best_id_in;
   logic [BURST_BITS-1:0]   best_burst_ff, best_burst_in;
   logic [TIME_BITS-1:0]    best_age_ff, best_age_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;
   rsp_user_type            rsp_user_ff, rsp_user_in;

   // Store write and valid strobes.
   logic                    slot_wr_en;
   logic                    slot_clr_en;

   req_data_type            req_data;
   logic                    req_fire;
   logic [IDX_BITS-1:0]     free_idx;
   logic                    cand_valid;
   logic [BURST_BITS-1:0]   cand_burst;
   logic [TIME_BITS-1:0]    cand_age;
   logic                    cand_take;
   logic [BURST_BITS-1:0]   rem_dec;

   assign req_data   = req_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Lowest free slot; only used when the store is not full.
   always_comb begin
      free_idx = '0;
      for (int i = READY_DEPTH - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   // Shared comparator: shorter burst wins, then the older arrival.
   assign cand_valid = slot_valid_ff[scan_idx_ff];
   assign cand_burst = slot_burst_ff[scan_idx_ff];
   assign cand_age   = arrival_cnt_ff - slot_order_ff[scan_idx_ff];
   assign cand_take  = cand_valid &&
                       (!found_ff || (cand_burst < best_burst_ff) ||
                        ((cand_burst == best_burst_ff) && (cand_age > best_age_ff)));

   assign rem_dec = run_rem_ff - BURST_BITS'(1);

   // Sequencer and next-state logic.
   always_comb begin
      state_in       = state_ff;
      arrival_cnt_in = arrival_cnt_ff;
      ready_cnt_in   = ready_cnt_ff;
      run_active_in  = run_active_ff;
      run_id_in      = run_id_ff;
      run_burst_in   = run_burst_ff;
      run_rem_in     = run_rem_ff;
      tick_cnt_in    = tick_cnt_ff;
      scan_idx_in    = scan_idx_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_id_in     = best_id_ff;
      best_burst_in  = best_burst_ff;
      best_age_in    = best_age_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      slot_wr_en     = 1'b0;
      slot_clr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == OP_ARRIVE) begin
                  rsp_user_in.finished = 1'b0;
                  if (req_data.burst_time == '0) begin
                     rsp_user_in.status = STATUS_ZERO;
                  end else if (ready_cnt_ff == FULL_CNT) begin
                     rsp_user_in.status = STATUS_FULL;
                  end else begin
                     rsp_user_in.status = STATUS_OK;
                     slot_wr_en     = 1'b1;
                     arrival_cnt_in = arrival_cnt_ff + TIME_BITS'(1);
                     ready_cnt_in   = ready_cnt_ff + CNT_BITS'(1);
                  end
                  rsp_data_in.pad            = '0;
                  rsp_data_in.finished_id    = '0;
                  rsp_data_in.finished_burst = '0;
                  rsp_data_in.finish_time    = '0;
                  rsp_data_in.busy_res       = run_active_ff;
                  rsp_data_in.running_id     = run_active_ff ? run_id_ff : '0;
                  rsp_data_in.ready_count    = ready_cnt_in;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end else if (!run_active_ff && (ready_cnt_ff != '0)) begin
                  scan_idx_in = '0;
                  found_in    = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_TICK;
               end
            end
         end

         ST_SCAN: begin
            if (cand_take) begin
               found_in      = 1'b1;
               best_idx_in   = scan_idx_ff;
               best_id_in    = slot_id_ff[scan_idx_ff];
               best_burst_in = cand_burst;
               best_age_in   = cand_age;
            end
            scan_idx_in = scan_idx_ff + IDX_BITS'(1);
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_START;
            end
         end

         ST_START: begin
            // The chosen job leaves the store and starts running.
            if (found_ff) begin
               slot_clr_en   = 1'b1;
               ready_cnt_in  = ready_cnt_ff - CNT_BITS'(1);
               run_active_in = 1'b1;
               run_id_in     = best_id_ff;
               run_burst_in  = best_burst_ff;
               run_rem_in    = best_burst_ff;
            end
            state_in = ST_TICK;
         end

         ST_TICK: begin
            tick_cnt_in                = tick_cnt_ff + TIME_BITS'(1);
            rsp_user_in.status         = STATUS_OK;
            rsp_user_in.finished       = 1'b0;
            rsp_data_in.pad            = '0;
            rsp_data_in.finished_id    = '0;
            rsp_data_in.finished_burst = '0;
            rsp_data_in.finish_time    = '0;
            if (run_active_ff) begin
               run_rem_in = rem_dec;
               if (rem_dec == '0) begin
                  rsp_user_in.finished       = 1'b1;
                  rsp_data_in.finished_id    = run_id_ff;
                  rsp_data_in.finished_burst = run_burst_ff;
                  rsp_data_in.finish_time    = tick_cnt_in;
                  run_active_in = 1'b0;
                  run_id_in     = '0;
                  run_burst_in  = '0;
               end
            end
            rsp_data_in.busy_res    = run_active_in;
            rsp_data_in.running_id  = run_active_in ? run_id_in : '0;
            rsp_data_in.ready_count = ready_cnt_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         arrival_cnt_ff <= '0;
         ready_cnt_ff   <= '0;
         run_active_ff  <= 1'b0;
         run_id_ff      <= '0;
         run_burst_ff   <= '0;
         run_rem_ff     <= '0;
         tick_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         slot_valid_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         arrival_cnt_ff <= arrival_cnt_in;
         ready_cnt_ff   <= ready_cnt_in;
         run_active_ff  <= run_active_in;
         run_id_ff      <= run_id_in;
         run_burst_ff   <= run_burst_in;
         run_rem_ff     <= run_rem_in;
         tick_cnt_ff    <= tick_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (slot_wr_en) begin
            slot_valid_ff[free_idx] <= 1'b1;
         end
         if (slot_clr_en) begin
            slot_valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_id_ff    <= best_id_in;
      best_burst_ff <= best_burst_in;
      best_age_ff   <= best_age_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      if (slot_wr_en) begin
         slot_id_ff[free_idx]    <= req_data.process_id;
         slot_burst_ff[free_idx] <= req_data.burst_time;
         slot_order_ff[free_idx] <= arrival_cnt_ff;
      end
   end

   // Checks on the scheduler's own bookkeeping.
   `SJF_ASSERT_ALWAYS(a_count_matches, clock, reset,
      ready_cnt_ff == CNT_BITS'($countones(slot_valid_ff)),
      "ready count differs from the number of valid slots")
   `SJF_ASSERT_SAME(a_running_has_time, clock, reset, run_active_ff,
      run_rem_ff != '0, "running job has no remaining time")
   `SJF_ASSERT_ALWAYS(a_one_item_at_a_time, clock, reset, !(req_tready && rsp_tvalid),
      "request accepted while a result is pending")
   `SJF_ASSERT_NEXT(a_start_removes_job, clock, reset, (state_ff == ST_START) && found_ff,
      run_active_ff && !slot_valid_ff[$past(best_idx_ff)],
      "started job still waits in the store")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-job-first scheduler. A driver sends
// arrival and tick items from a queue and a monitor takes the result items.
// A scheduler model inside the bench predicts each result and checks it
// field by field. Both sides idle in random bursts, and once the receiver
// stalls for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import sjf_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int QUIET_TAIL   = 120;      // Items at the end sent with no idling.
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   // One arrival or tick as the bench sees it.
   typedef struct {
      logic                  op;
      logic [ID_BITS-1:0]    pid;
      logic [BURST_BITS-1:0] len;
   } job_item_type;

   // One predicted result item.
   typedef struct {
      rsp_user_type user;
      rsp_data_type data;
   } job_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_tvalid;
   logic                          req_tready;
   logic [ID_BITS+BURST_BITS-1:0] req_tdata;   // process_id, burst_time
   logic [0:0]                    req_tuser;   // operation
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [RSP_DATA_BITS-1:0]      rsp_tdata;   // finished_id .. ready_count
   logic [2:0]                    rsp_tuser;   // status, finished

   sjf_nonpreemptive_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Scheduler state as the bench tracks it.
   bit                  slot_used [READY_DEPTH];
   bit [ID_BITS-1:0]    slot_pid  [READY_DEPTH];
   bit [BURST_BITS-1:0] slot_len  [READY_DEPTH];
   bit [31:0]           slot_seq  [READY_DEPTH];
   bit [31:0]           arrivals_taken;
   bit                  cpu_busy;
   bit [ID_BITS-1:0]    cpu_pid;
   bit [BURST_BITS-1:0] cpu_len;
   bit [BURST_BITS-1:0] cpu_left;
   bit [TIME_BITS-1:0]  now_ticks;

   job_item_type    job_items[$];
   job_outcome_type predicted_outcomes[$];
   job_item_type    cur_item;

   int send_gap, take_gap;
   bit send_calm, take_calm;
   logic tail_quiet;
   int hold_left;
   bit hold_done;
   int results_seen;
   int mismatches;
   int cycles;
   int items_sent, full_drops, zero_rejects, ticks_seen, jobs_done;

   // Applies one accepted item to the tracked state and queues its result.
   function automatic void predict_schedule(job_item_type it);
      job_outcome_type r;
      int              i, pick, free_slot, waiting;
      bit [31:0]       age_i, age_p;
      r.user = '0;
      r.data = '0;
      items_sent++;
      if (it.op == OP_ARRIVE) begin
         if (it.len == '0) begin
            r.user.status = STATUS_ZERO;
            zero_rejects++;
         end else begin
            free_slot = -1;
            for (i = READY_DEPTH - 1; i >= 0; i--)
               if (!slot_used[i]) free_slot = i;
            if (free_slot < 0) begin
               r.user.status = STATUS_FULL;
               full_drops++;
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_pid[free_slot]  = it.pid;
               slot_len[free_slot]  = it.len;
               slot_seq[free_slot]  = arrivals_taken;
               arrivals_taken++;
            end
         end
      end else begin
         ticks_seen++;
         // Start the shortest waiting job; the oldest one wins a tie.
         if (!cpu_busy) begin
            pick = -1;
            for (i = 0; i < READY_DEPTH; i++) begin
               if (slot_used[i]) begin
                  if (pick < 0 || slot_len[i] < slot_len[pick]) begin
                     pick = i;
                  end else if (slot_len[i] == slot_len[pick]) begin
                     age_i = arrivals_taken - slot_seq[i];
                     age_p = arrivals_taken - slot_seq[pick];
                     if (age_i > age_p) pick = i;
                  end
               end
            end
            if (pick >= 0) begin
               slot_used[pick] = 1'b0;
               cpu_busy = 1'b1;
               cpu_pid  = slot_pid[pick];
               cpu_len  = slot_len[pick];
               cpu_left = slot_len[pick];
            end
         end
         now_ticks++;
         if (cpu_busy) begin
            cpu_left--;
            if (cpu_left == '0) begin
               r.user.finished      = 1'b1;
               r.data.finished_id    = cpu_pid;
               r.data.finished_burst = cpu_len;
               r.data.finish_time    = now_ticks;
               cpu_busy = 1'b0;
               cpu_pid  = '0;
               cpu_len  = '0;
               jobs_done++;
            end
         end
      end
      waiting = 0;
      for (i = 0; i < READY_DEPTH; i++)
         if (slot_used[i]) waiting++;
      r.data.busy_res    = cpu_busy;
      r.data.running_id  = cpu_busy ? cpu_pid : '0;
      r.data.ready_count = CNT_BITS'(waiting);
      predicted_outcomes.push_back(r);
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
      end
   endfunction

   function automatic void add_job(logic op, logic [ID_BITS-1:0] pid,
                                   logic [BURST_BITS-1:0] len);
      job_item_type it;
      it.op  = op;
      it.pid = pid;
      it.len = len;
      job_items.push_back(it);
   endfunction

   // Driver: presents queued items and idles between them in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         tail_quiet <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_schedule(cur_item);
         if (!req_tvalid || req_tready) begin
            if (send_gap == 0 && !send_calm && job_items.size() > QUIET_TAIL &&
                $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 12);
            if (send_gap > 0 || job_items.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               cur_item = job_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_item.len, cur_item.pid};
               req_tuser  <= cur_item.op;
            end
         end
         if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
         tail_quiet <= (job_items.size() <= QUIET_TAIL);
      end
   end

   // Monitor: checks each result item against the oldest prediction.
   always @(posedge clock) begin
      job_outcome_type want;
      rsp_data_type    got_d;
      rsp_user_type    got_u;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            got_d = rsp_data_type'(rsp_tdata);
            got_u = rsp_user_type'(rsp_tuser);
            if (predicted_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result item with none predicted: user 0x%0h data 0x%0h",
                           $time, rsp_tuser, rsp_tdata);
            end else begin
               want = predicted_outcomes.pop_front();
               check_field("status", want.user.status, got_u.status);
               check_field("finished", want.user.finished, got_u.finished);
               check_field("finished_id", want.data.finished_id, got_d.finished_id);
               check_field("finished_burst", want.data.finished_burst,
                           got_d.finished_burst);
               check_field("finish_time", want.data.finish_time, got_d.finish_time);
               check_field("busy_res", want.data.busy_res, got_d.busy_res);
               check_field("running_id", want.data.running_id, got_d.running_id);
               check_field("ready_count", want.data.ready_count, got_d.ready_count);
               check_field("pad", want.data.pad, got_d.pad);
            end
         end
         if (take_gap == 0 && !take_calm && !tail_quiet && $urandom_range(0, 5) == 0)
            take_gap = $urandom_range(1, 12);
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_left == 0);
         end
         if ($urandom_range(0, 149) == 0) take_calm = !take_calm;
      end
   end

   // Long receiver hold-off once, so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run stopped at cycle limit with %0d results outstanding",
                  predicted_outcomes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int blk, k, arrive_pct, pick;
      // Idle tick, then a zero burst into the empty store.
      add_job(OP_TICK, 8'hFF, 16'hFFFF);
      add_job(OP_ARRIVE, 8'h00, 16'h0000);
      // Tie on burst where the older job sits in a higher slot.
      add_job(OP_ARRIVE, 8'h00, 16'd2);
      add_job(OP_ARRIVE, 8'hFF, 16'd3);
      add_job(OP_ARRIVE, 8'h5A, 16'd2);
      add_job(OP_TICK, 8'h00, 16'h0000);
      add_job(OP_ARRIVE, 8'hA5, 16'd3);
      add_job(OP_TICK, 8'h00, 16'h0000);
      add_job(OP_TICK, 8'h00, 16'h0000);
      add_job(OP_TICK, 8'h00, 16'h0000);
      add_job(OP_TICK, 8'h00, 16'h0000);
      // Fill the store, then a drop on full and a zero burst into the full store.
      add_job(OP_ARRIVE, 8'h81, 16'd1);
      for (k = 0; k < 14; k++)
         add_job(OP_ARRIVE, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 3)));
      add_job(OP_ARRIVE, 8'h7E, 16'd7);
      add_job(OP_ARRIVE, 8'h18, 16'h0000);

      // Random traffic in blocks with a varying arrival share.
      for (blk = 0; blk < RANDOM_ITEMS / 125; blk++) begin
         arrive_pct = $urandom_range(25, 70);
         for (k = 0; k < 125; k++) begin
            if ($urandom_range(0, 99) < arrive_pct) begin
               pick = $urandom_range(0, 99);
               add_job(OP_ARRIVE, 8'($urandom_range(0, 255)),
                       pick < 4 ? 16'h0000 :
                       pick < 8 ? 16'($urandom_range(10, 60)) :
                                  16'($urandom_range(1, 5)));
            end else begin
               add_job(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
         end
      end

      // Long bursts at the end only, since a running one holds the scheduler.
      for (k = 0; k < 20; k++)
         add_job(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      add_job(OP_ARRIVE, 8'h3C, 16'hFFFF);
      add_job(OP_ARRIVE, 8'hC3, 16'h8000);
      add_job(OP_ARRIVE, 8'h0F, 16'h7FFF);
      for (k = 0; k < 4; k++)
         add_job(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (job_items.size() != 0 || req_tvalid) @(posedge clock);
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (predicted_outcomes.size() != 0) mismatches++;
      $display("Ran %0d items: %0d arrivals queued, %0d dropped on a full store, %0d zero bursts",
               items_sent, arrivals_taken, full_drops, zero_rejects);
      $display("%0d ticks, %0d jobs completed, %0d mismatches",
               ticks_seen, jobs_done, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
